// ----- rtl/amtu_pkg.sv -----
package amtu_pkg;

	typedef enum logic [3:0] {
		CMD_IDENTITY   = 4'd0,
		CMD_WR_CUR     = 4'd1,
		CMD_WR_OPD     = 4'd2,
		CMD_READ       = 4'd3,
		CMD_APPEND     = 4'd4,
		CMD_PREPEND    = 4'd5,
		CMD_SCALE_APP  = 4'd6,
		CMD_SCALE_PRE  = 4'd7,
		CMD_TRANS_APP  = 4'd8,
		CMD_TRANS_PRE  = 4'd9,
		CMD_POINT      = 4'd10,
		CMD_DIRECTION  = 4'd11,
		CMD_INTERP     = 4'd12
	} cmd_t;

	localparam int WEIGHT_BITS = 16;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;

	// Saturate a 64-bit signed sum to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		begin
			hi = 64'sd2147483647;
			lo = -64'sd2147483648;
			if (v > hi) begin
				sat32 = 32'sh7fffffff;
			end else if (v < lo) begin
				sat32 = 32'sh80000000;
			end else begin
				sat32 = v[31:0];
			end
		end
	endfunction

endpackage

// ----- rtl/amtu_ram.sv -----
module amtu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/amtu_mac.sv -----
module amtu_mac (
	input  logic               clk,
	input  logic               clr,
	input  logic               en,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic [5:0]         shift,
	output logic signed [63:0] acc_q
);
	logic signed [63:0] prod_s1;
	logic               en_s1;
	logic [5:0]         shift_s1;
	logic signed [63:0] shifted;

	assign shifted = prod_s1 >>> shift_s1;

	always_ff @(posedge clk) begin
		prod_s1  <= 64'(a) * 64'(b);
		en_s1    <= en;
		shift_s1 <= shift;
		if (clr) begin
			acc_q <= '0;
		end else if (en_s1) begin
			acc_q <= acc_q + shifted;
		end
	end
endmodule

// ----- rtl/affine_matrix4_transform_unit.sv -----
// Channel | Direction | Signals                                           | Handshake
// command | in        | cmd entry_index val_x val_y val_z fraction        | start & !busy
// result  | out       | out_x out_y out_z                                 | done, one cycle
// Writes are done without leaving the idle state; identity and the operand copy
// sweep the 16 entries. Vector transforms, interpolation and matrix products run
// on one shared multiply-accumulate unit fed from the two memories, and matrix
// products are followed by a write-back pass over all 16 entries.
// Reset clears control, then a pass over the 16 entries loads the identity and zeros the
// operand; busy is high during the pass. The receiver cannot stall results.
module affine_matrix4_transform_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         cmd,
	input  logic [3:0]         entry_index,
	input  logic signed [31:0] val_x,
	input  logic signed [31:0] val_y,
	input  logic signed [31:0] val_z,
	input  logic [16:0]        fraction,
	output logic               done,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);
	import amtu_pkg::*;

	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	typedef enum logic [6:0] {
		ST_INIT  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_RD    = 7'b0000100,
		ST_WAIT  = 7'b0001000,
		ST_ACC   = 7'b0010000,
		ST_WR    = 7'b0100000,
		ST_COPY  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [3:0] cmd_q;
	logic [3:0] idx_q;
	logic signed [31:0] vx_q, vy_q, vz_q;
	logic [16:0] frac_q;
	logic [3:0] ent_q;
	logic [2:0] k_q;
	logic [2:0] wt_q;
	logic signed [31:0] res_q [3];
	logic signed [31:0] tmp_q [16];

	logic cur_we, opd_we;
	logic [3:0] cur_wa, opd_wa, cur_ra, opd_ra;
	logic [31:0] cur_wd, opd_wd, cur_rd, opd_rd;

	amtu_ram #(.WIDTH(32), .DEPTH(16)) u_cur (
		.clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd),
		.raddr(cur_ra), .rdata(cur_rd));
	amtu_ram #(.WIDTH(32), .DEPTH(16)) u_opd (
		.clk(clk), .we(opd_we), .waddr(opd_wa), .wdata(opd_wd),
		.raddr(opd_ra), .rdata(opd_rd));

	logic mac_clr, mac_en;
	logic signed [31:0] mac_a, mac_b;
	logic [5:0] mac_sh;
	logic signed [63:0] acc;

	amtu_mac u_mac (
		.clk(clk), .clr(mac_clr), .en(mac_en), .a(mac_a), .b(mac_b),
		.shift(mac_sh), .acc_q(acc));

	logic [1:0] r, c;
	assign r = ent_q[3:2];
	assign c = ent_q[1:0];

	logic is_mul, is_vec, is_interp;
	assign is_mul = cmd_q == CMD_APPEND || cmd_q == CMD_PREPEND || cmd_q == CMD_SCALE_APP
		|| cmd_q == CMD_SCALE_PRE || cmd_q == CMD_TRANS_APP;
	assign is_vec = cmd_q == CMD_POINT || cmd_q == CMD_DIRECTION;
	assign is_interp = cmd_q == CMD_INTERP;

	// Number of multiply terms per entry.
	logic [2:0] nterms;
	always_comb begin
		if (is_interp) begin
			nterms = 3'd2;
		end else if (is_vec) begin
			nterms = (cmd_q == CMD_POINT) ? 3'd4 : 3'd3;
		end else begin
			nterms = 3'd4;
		end
	end

	// Entry of the factor matrices at (row, col).
	function automatic logic signed [31:0] fac(input logic [3:0] cm, input logic [1:0] rr,
			input logic [1:0] cc, input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic signed [31:0] one);
		logic signed [31:0] v;
		begin
			v = '0;
			if (rr == cc) begin
				if (cm == CMD_TRANS_APP || rr == 2'd3) begin
					v = one;
				end else begin
					v = (rr == 2'd0) ? x : (rr == 2'd1) ? y : z;
				end
			end
			if (cm == CMD_TRANS_APP && rr == 2'd3 && cc != 2'd3) begin
				v = (cc == 2'd0) ? x : (cc == 2'd1) ? y : z;
			end
			fac = v;
		end
	endfunction

	// Read addresses for term k of the current entry.
	logic [1:0] kk;
	assign kk = k_q[1:0];
	always_comb begin
		cur_ra = '0;
		opd_ra = '0;
		if (state_q == ST_COPY) begin
			opd_ra = ent_q;
		end else if (is_interp) begin
			cur_ra = ent_q;
			opd_ra = ent_q;
		end else if (is_vec) begin
			cur_ra = {kk, c};
		end else if (cmd_q == CMD_APPEND || cmd_q == CMD_SCALE_APP || cmd_q == CMD_TRANS_APP) begin
			cur_ra = {kk, c};
			opd_ra = {r, kk};
		end else if (cmd_q == CMD_PREPEND || cmd_q == CMD_SCALE_PRE) begin
			cur_ra = {r, kk};
			opd_ra = {kk, c};
		end else if (cmd_q == CMD_TRANS_PRE) begin
			cur_ra = ent_q;
		end else begin
			cur_ra = idx_q;
		end
	end

	// Operand select in the cycle after the read, when data is valid.
	logic [2:0] kd_q;
	logic       rv_q;
	logic [1:0] kd;
	logic signed [31:0] wvec;
	assign kd = kd_q[1:0];
	always_comb begin
		mac_a = '0;
		mac_b = '0;
		mac_sh = 6'(FRAC_BITS);
		case (kd)
			2'd0: wvec = vx_q;
			2'd1: wvec = vy_q;
			default: wvec = vz_q;
		endcase
		if (is_interp) begin
			mac_sh = 6'(WEIGHT_BITS);
			if (kd_q == 3'd0) begin
				mac_a = cur_rd;
				mac_b = 32'(WEIGHT_ONE - frac_q);
			end else begin
				mac_a = opd_rd;
				mac_b = 32'(frac_q);
			end
		end else if (is_vec) begin
			if (kd == 2'd3) begin
				mac_a = cur_rd;
				mac_b = ONE;
			end else begin
				mac_a = wvec;
				mac_b = cur_rd;
			end
		end else if (cmd_q == CMD_APPEND || cmd_q == CMD_PREPEND) begin
			mac_a = opd_rd;
			mac_b = cur_rd;
		end else if (cmd_q == CMD_SCALE_APP || cmd_q == CMD_TRANS_APP) begin
			mac_a = fac(cmd_q, r, kd, vx_q, vy_q, vz_q, ONE);
			mac_b = cur_rd;
		end else begin
			mac_a = cur_rd;
			mac_b = fac(cmd_q, kd, c, vx_q, vy_q, vz_q, ONE);
		end
	end
	assign mac_en = rv_q;
	assign mac_clr = state_q == ST_RD && k_q == 3'd0;

	logic signed [31:0] satv;
	assign satv = sat32(acc);

	logic signed [31:0] addv;
	always_comb begin
		case (ent_q[1:0])
			2'd0: addv = vx_q;
			2'd1: addv = vy_q;
			default: addv = vz_q;
		endcase
	end

	always_comb begin
		cur_we = 1'b0;
		cur_wa = ent_q;
		cur_wd = satv;
		opd_we = 1'b0;
		opd_wa = ent_q;
		opd_wd = '0;
		if (state_q == ST_INIT) begin
			cur_we = 1'b1;
			cur_wd = (ent_q[3:2] == ent_q[1:0]) ? ONE : '0;
			opd_we = 1'b1;
		end else if (state_q == ST_COPY) begin
			if (cmd_q == CMD_IDENTITY) begin
				cur_we = 1'b1;
				cur_wd = (ent_q[3:2] == ent_q[1:0]) ? ONE : '0;
			end else if (rv_q) begin
				cur_we = 1'b1;
				cur_wa = ent_q - 4'd1;
				cur_wd = opd_rd;
			end
		end else if (state_q == ST_IDLE && start) begin
			cur_we = cmd == CMD_WR_CUR;
			cur_wa = entry_index;
			cur_wd = val_x;
			opd_we = cmd == CMD_WR_OPD;
			opd_wa = entry_index;
			opd_wd = val_x;
		end else if (state_q == ST_WR) begin
			cur_we = 1'b1;
			cur_wd = tmp_q[ent_q];
		end
	end

	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ent_q <= '0;
			k_q <= '0;
			kd_q <= '0;
			rv_q <= 1'b0;
			wt_q <= '0;
			done <= 1'b0;
			cmd_q <= '0;
		end else begin
			done <= 1'b0;
			rv_q <= 1'b0;
			kd_q <= k_q;
			case (state_q)
				ST_INIT: begin
					ent_q <= ent_q + 4'd1;
					if (ent_q == 4'd15) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						idx_q <= entry_index;
						vx_q <= val_x;
						vy_q <= val_y;
						vz_q <= val_z;
						frac_q <= fraction;
						res_q[0] <= '0;
						res_q[1] <= '0;
						res_q[2] <= '0;
						ent_q <= '0;
						k_q <= '0;
						if (cmd == CMD_IDENTITY) begin
							state_q <= ST_COPY;
						end else if (cmd == CMD_INTERP && fraction == '0) begin
							done <= 1'b1;
							out_x <= '0;
							out_y <= '0;
							out_z <= '0;
						end else if (cmd == CMD_INTERP && fraction >= WEIGHT_ONE) begin
							state_q <= ST_COPY;
						end else if (cmd == CMD_TRANS_PRE) begin
							ent_q <= 4'd12;
							state_q <= ST_RD;
						end else if (cmd == CMD_READ || (cmd >= CMD_APPEND && cmd <= CMD_INTERP))
								begin
							state_q <= ST_RD;
						end else begin
							done <= 1'b1;
							out_x <= '0;
							out_y <= '0;
							out_z <= '0;
						end
					end
				end
				ST_COPY: begin
					ent_q <= ent_q + 4'd1;
					rv_q <= cmd_q != CMD_IDENTITY;
					if (cmd_q == CMD_IDENTITY && ent_q == 4'd15) begin
						state_q <= ST_IDLE;
						done <= 1'b1;
						out_x <= '0;
						out_y <= '0;
						out_z <= '0;
					end else if (cmd_q != CMD_IDENTITY && rv_q && ent_q == 4'd0) begin
						state_q <= ST_IDLE;
						rv_q <= 1'b0;
						done <= 1'b1;
						out_x <= '0;
						out_y <= '0;
						out_z <= '0;
					end
				end
				ST_RD: begin
					if (cmd_q == CMD_READ || cmd_q == CMD_TRANS_PRE) begin
						state_q <= ST_WAIT;
						wt_q <= '0;
					end else begin
						rv_q <= 1'b1;
						k_q <= k_q + 3'd1;
						if (k_q == nterms - 3'd1) begin
							state_q <= ST_WAIT;
							wt_q <= '0;
						end
					end
				end
				ST_WAIT: begin
					wt_q <= wt_q + 3'd1;
					if (cmd_q == CMD_READ) begin
						done <= 1'b1;
						out_x <= cur_rd;
						out_y <= '0;
						out_z <= '0;
						state_q <= ST_IDLE;
					end else if (cmd_q == CMD_TRANS_PRE) begin
						tmp_q[ent_q] <= sat32(64'(signed'(cur_rd)) + 64'(addv));
						state_q <= ST_WR;
					end else if (wt_q == 3'd2) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					k_q <= '0;
					if (is_vec) begin
						res_q[c] <= satv;
						if (c == 2'd2) begin
							done <= 1'b1;
							out_x <= res_q[0];
							out_y <= res_q[1];
							out_z <= satv;
							state_q <= ST_IDLE;
						end else begin
							ent_q <= ent_q + 4'd1;
							state_q <= ST_RD;
						end
					end else begin
						tmp_q[ent_q] <= satv;
						if (is_interp) begin
							state_q <= ST_WR;
						end else if (ent_q == 4'd15) begin
							ent_q <= '0;
							state_q <= ST_WR;
						end else begin
							ent_q <= ent_q + 4'd1;
							state_q <= ST_RD;
						end
					end
				end
				ST_WR: begin
					if (cmd_q == CMD_TRANS_PRE) begin
						if (ent_q == 4'd14) begin
							state_q <= ST_IDLE;
							done <= 1'b1;
							out_x <= '0;
							out_y <= '0;
							out_z <= '0;
						end else begin
							ent_q <= ent_q + 4'd1;
							state_q <= ST_RD;
						end
					end else if (is_interp) begin
						if (ent_q == 4'd15) begin
							state_q <= ST_IDLE;
							done <= 1'b1;
							out_x <= '0;
							out_y <= '0;
							out_z <= '0;
						end else begin
							ent_q <= ent_q + 4'd1;
							state_q <= ST_RD;
						end
					end else begin
						ent_q <= ent_q + 4'd1;
						if (ent_q == 4'd15) begin
							state_q <= ST_IDLE;
							done <= 1'b1;
							out_x <= '0;
							out_y <= '0;
							out_z <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT |-> !done) else $error("result during init");
	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT |-> busy) else $error("ready during init");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_IDLE) else $error("result while working");
endmodule
